// File: rtl/zyz_pkg.sv
// shared constants, types and functions for the zyz euler angle block
package zyz_pkg;

  // internal angle width, signed q.16 radians
  localparam int ZW        = 20;
  // datapath width of the phi and sin/cos chains
  localparam int PW        = 20;
  // datapath width of the theta and psi chains
  localparam int TW        = 40;
  // product width, PW x 16
  localparam int MW        = PW + 16;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] PI_Q16      = ZW'(205887);
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
  localparam logic signed [PW-1:0] KINV_Q16    = PW'(39797);
  localparam logic signed [15:0]   OUT_LIMIT   = 16'sd25736;

  // matrix word carried alongside the phi and sin/cos rows of the pipeline
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
    logic               phi_zero;
  } mat_t;

  // phi and quadrant fold flag
  typedef struct packed {
    logic signed [ZW-1:0] phi;
    logic                 neg;
  } phl_t;

  // degenerate atan2 flags for theta and psi
  typedef struct packed {
    logic theta_zero;
    logic psi_zero;
  } tpz_t;

  // round(atan(2^-i) * 65536)
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic [16:0] v;
    unique case (idx)
      0:       v = 17'd51472;
      1:       v = 17'd30386;
      2:       v = 17'd16055;
      3:       v = 17'd8150;
      4:       v = 17'd4091;
      5:       v = 17'd2047;
      6:       v = 17'd1024;
      7:       v = 17'd512;
      8:       v = 17'd256;
      9:       v = 17'd128;
      10:      v = 17'd64;
      11:      v = 17'd32;
      12:      v = 17'd16;
      13:      v = 17'd8;
      14:      v = 17'd4;
      15:      v = 17'd2;
      16:      v = 17'd1;
      default: v = 17'd0;
    endcase
    return ZW'($signed({1'b0, v}));
  endfunction

  // q.16 angle to q3.13, half up, saturated
  function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] a);
    logic signed [ZW:0]   b;
    logic signed [ZW-3:0] r;
    b = (ZW+1)'(a) + (ZW+1)'(4);
    r = (ZW-2)'(b >>> 3);
    if (r > (ZW-2)'(OUT_LIMIT)) begin
      return OUT_LIMIT;
    end else if (r < -(ZW-2)'(OUT_LIMIT)) begin
      return -OUT_LIMIT;
    end
    return 16'(r);
  endfunction

endpackage

// File: rtl/zyz_cell.sv
// one cordic micro-rotation cell with its x, y and z registers
module zyz_cell import zyz_pkg::*; #(
  parameter int W     = 20,
  parameter int SHIFT = 0,
  parameter bit VECT  = 1'b1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [W-1:0]  dx, dy, x_nxt, y_nxt;
  logic signed [ZW-1:0] ang, z_nxt;
  logic                 up;
  logic signed [W-1:0]  x_r, y_r;
  logic signed [ZW-1:0] z_r;

  // direction: vectoring drives y to zero, rotation drives z to zero
  assign dx  = y_i >>> SHIFT;
  assign dy  = x_i >>> SHIFT;
  assign ang = atan_q16(SHIFT);
  assign up  = VECT ? !y_i[W-1] : z_i[ZW-1];

  always_comb begin
    x_nxt = up ? x_i + dx : x_i - dx;
    y_nxt = up ? y_i - dy : y_i + dy;
    z_nxt = up ? z_i + ang : z_i - ang;
  end

  // cell registers
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// File: rtl/zyz_chain.sv
// row of cordic cells, with quarter-turn prerotation in vectoring mode
module zyz_chain import zyz_pkg::*; #(
  parameter int W      = 20,
  parameter int STAGES = 16,
  parameter bit VECT   = 1'b1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [W-1:0]  xw [STAGES+1];
  logic signed [W-1:0]  yw [STAGES+1];
  logic signed [ZW-1:0] zw [STAGES+1];
  logic signed [W-1:0]  x0, y0;
  logic signed [ZW-1:0] z0;

  // prerotation brings a left half plane vector to the right
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = z_i;
    if (VECT && x_i[W-1]) begin
      if (!y_i[W-1]) begin
        x0 = y_i;
        y0 = -x_i;
        z0 = z_i + HALF_PI_Q16;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        z0 = z_i - HALF_PI_Q16;
      end
    end
  end

  assign xw[0] = x0;
  assign yw[0] = y0;
  assign zw[0] = z0;

  // cells
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    zyz_cell #(.W(W), .SHIFT(i), .VECT(VECT)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (xw[i]),
      .y_i (yw[i]),
      .z_i (zw[i]),
      .x_o (xw[i+1]),
      .y_o (yw[i+1]),
      .z_o (zw[i+1])
    );
  end

  assign x_o = xw[STAGES];
  assign y_o = yw[STAGES];
  assign z_o = zw[STAGES];

endmodule

// File: rtl/rotation_matrix_to_zyz_euler.sv
// ZYZ euler angles from a rotation matrix. One matrix word is taken per
// clock and one angle word leaves per clock; the path runs through
// three cordic cell rows in series (phi atan2, sin/cos of
// phi, then theta and psi atan2 side by side) plus a product register and
// the output register. A stall on the output holds the whole pipeline.
module rotation_matrix_to_zyz_euler import zyz_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_m00,
  input  logic signed [15:0] in_m01,
  input  logic signed [15:0] in_m02,
  input  logic signed [15:0] in_m10,
  input  logic signed [15:0] in_m11,
  input  logic signed [15:0] in_m12,
  input  logic signed [15:0] in_m22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_phi,
  output logic signed [15:0] out_theta,
  output logic signed [15:0] out_psi
);

  localparam int N = CORDIC_STAGES;
  localparam int L = 3 * N + 2;

  logic              en;
  logic [10:0]       thr_r;
  logic [L-1:0]      vld_r;
  mat_t              mat_r [2*N];
  phl_t              phl_r [2*N+1];
  tpz_t              tpz_r [N];
  mat_t              mat_nxt;
  phl_t              phl_nxt;
  tpz_t              tpz_nxt;
  logic [16:0]       a12, a02;
  logic signed [ZW-1:0] phz, sc_z;
  logic signed [PW-1:0] sc_x, sc_y, cs_c, cs_s;
  logic signed [PW-1:0] cos_v, sin_v;
  logic signed [ZW-1:0] th_z, ps_z;
  logic signed [MW-1:0] p_cm02_r, p_sm12_r, p_sm00_r, p_cm10_r, p_sm01_r, p_cm11_r;
  logic signed [15:0]   m22_r;
  logic signed [TW-1:0] ty, tx, py, px;
  logic signed [15:0]   out_phi_r, out_theta_r, out_psi_r;

  assign en       = !vld_r[L-1] || out_ready;
  assign in_ready = en;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 11'd1;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  // input word and near-zero decision
  always_comb begin
    a12 = in_m12[15] ? 17'(-18'(in_m12)) : 17'(in_m12);
    a02 = in_m02[15] ? 17'(-18'(in_m02)) : 17'(in_m02);
    mat_nxt.m00 = in_m00;
    mat_nxt.m01 = in_m01;
    mat_nxt.m02 = in_m02;
    mat_nxt.m10 = in_m10;
    mat_nxt.m11 = in_m11;
    mat_nxt.m12 = in_m12;
    mat_nxt.m22 = in_m22;
    mat_nxt.phi_zero = (a12 < 17'(thr_r) && a02 < 17'(thr_r)) ||
                       (in_m12 == '0 && in_m02 == '0);
  end

  // phi = atan2(m12, m02)
  zyz_chain #(.W(PW), .STAGES(N), .VECT(1'b1)) u_phi (
    .clk (clk),
    .en  (en),
    .x_i (PW'(in_m02)),
    .y_i (PW'(in_m12)),
    .z_i ('0),
    .x_o (),
    .y_o (),
    .z_o (phz)
  );

  // fold phi into +-pi/2 for sin/cos
  always_comb begin
    phl_nxt.phi = mat_r[N-1].phi_zero ? '0 : phz;
    phl_nxt.neg = 1'b0;
    sc_z        = phl_nxt.phi;
    if (phl_nxt.phi > HALF_PI_Q16) begin
      sc_z        = phl_nxt.phi - PI_Q16;
      phl_nxt.neg = 1'b1;
    end else if (phl_nxt.phi < -HALF_PI_Q16) begin
      sc_z        = phl_nxt.phi + PI_Q16;
      phl_nxt.neg = 1'b1;
    end
  end

  zyz_chain #(.W(PW), .STAGES(N), .VECT(1'b0)) u_sincos (
    .clk (clk),
    .en  (en),
    .x_i (KINV_Q16),
    .y_i ('0),
    .z_i (sc_z),
    .x_o (sc_x),
    .y_o (sc_y),
    .z_o ()
  );

  assign cs_c  = sc_x;
  assign cs_s  = sc_y;
  assign cos_v = phl_r[N-1].neg ? -cs_c : cs_c;
  assign sin_v = phl_r[N-1].neg ? -cs_s : cs_s;

  // payload delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      mat_r[0] <= mat_nxt;
      for (int k = 1; k < 2*N; k++) begin
        mat_r[k] <= mat_r[k-1];
      end
      phl_r[0] <= phl_nxt;
      for (int k = 1; k < 2*N+1; k++) begin
        phl_r[k] <= phl_r[k-1];
      end
      tpz_r[0] <= tpz_nxt;
      for (int k = 1; k < N; k++) begin
        tpz_r[k] <= tpz_r[k-1];
      end
    end
  end

  // products of cos/sin with matrix entries
  always_ff @(posedge clk) begin
    if (en) begin
      p_cm02_r <= MW'(cos_v) * MW'(mat_r[2*N-1].m02);
      p_sm12_r <= MW'(sin_v) * MW'(mat_r[2*N-1].m12);
      p_sm00_r <= MW'(sin_v) * MW'(mat_r[2*N-1].m00);
      p_cm10_r <= MW'(cos_v) * MW'(mat_r[2*N-1].m10);
      p_sm01_r <= MW'(sin_v) * MW'(mat_r[2*N-1].m01);
      p_cm11_r <= MW'(cos_v) * MW'(mat_r[2*N-1].m11);
      m22_r    <= mat_r[2*N-1].m22;
    end
  end

  // atan2 operands for theta and psi
  always_comb begin
    ty = TW'(p_cm02_r) + TW'(p_sm12_r);
    tx = TW'(m22_r) <<< 16;
    py = TW'(p_cm10_r) - TW'(p_sm00_r);
    px = TW'(p_cm11_r) - TW'(p_sm01_r);
    tpz_nxt.theta_zero = (ty == '0) && (tx == '0);
    tpz_nxt.psi_zero   = (py == '0) && (px == '0);
  end

  zyz_chain #(.W(TW), .STAGES(N), .VECT(1'b1)) u_theta (
    .clk (clk),
    .en  (en),
    .x_i (tx),
    .y_i (ty),
    .z_i ('0),
    .x_o (),
    .y_o (),
    .z_o (th_z)
  );

  zyz_chain #(.W(TW), .STAGES(N), .VECT(1'b1)) u_psi (
    .clk (clk),
    .en  (en),
    .x_i (px),
    .y_i (py),
    .z_i ('0),
    .x_o (),
    .y_o (),
    .z_o (ps_z)
  );

  // output register with rounding
  always_ff @(posedge clk) begin
    if (en) begin
      out_phi_r   <= to_out(phl_r[2*N].phi);
      out_theta_r <= tpz_r[N-1].theta_zero ? '0 : to_out(th_z);
      out_psi_r   <= tpz_r[N-1].psi_zero ? '0 : to_out(ps_z);
    end
  end

  assign out_valid = vld_r[L-1];
  assign out_phi   = out_phi_r;
  assign out_theta = out_theta_r;
  assign out_psi   = out_psi_r;

endmodule

// File: rtl/zyz_checker.sv
// port-level checks for the zyz euler angle block, bound to the top level
module zyz_assertions (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_phi,
  input logic signed [15:0] out_theta,
  input logic signed [15:0] out_psi
);

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phi) &&
    $stable(out_theta) && $stable(out_psi))
    else $error("stalled output word changed");

  // input side only stalls when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // angles stay within saturation limits
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phi <= 16'sd25736 && out_phi >= -16'sd25736 &&
    out_theta <= 16'sd25736 && out_theta >= -16'sd25736 &&
    out_psi <= 16'sd25736 && out_psi >= -16'sd25736)
    else $error("output angle out of range");

endmodule

bind rotation_matrix_to_zyz_euler zyz_assertions u_zyz_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_phi   (out_phi),
  .out_theta (out_theta),
  .out_psi   (out_psi)
);
